/* rtl/mccp_pkg.sv */
// Package for the motor command packer: word types, request codes and the
// clamp and scaling constants shared by the datapath stages. No dependencies.
package mccp_pkg;

   localparam int FRAC_BITS = 8;
   localparam int ONE_FX    = 1 << FRAC_BITS;

   // Clamp limits in fixed point
   localparam int POS_LIM = 191 * (ONE_FX / 2);   // 95.5
   localparam int VEL_LIM = 30 * ONE_FX;
   localparam int KP_LIM  = 100 * ONE_FX;
   localparam int KD_LIM  = 5 * ONE_FX;
   localparam int TRQ_LIM = 18 * ONE_FX;

   // code = floor(off * maxcode / span), with maxcode/span reduced for 8 fraction bits:
   //   position  65535 / (256 * 191)  -> (off * 65535) >> 8, then divide by 191
   //   velocity  4095 / 15360 = 273 / 1024
   //   stiffness 4095 / 128000 = 819 / (1024 * 25) -> (kp * 819) >> 10, then divide by 25
   //   damping   4095 / 1280 = 819 / 256
   //   torque    4095 / 9216 = 455 / 1024
   localparam logic [31:0] POS_MUL = 32'd65535;
   localparam logic [23:0] VEL_MUL = 24'd273;
   localparam logic [25:0] KP_MUL  = 26'd819;
   localparam logic [19:0] KD_MUL  = 20'd819;
   localparam logic [23:0] TRQ_MUL = 24'd455;

   // Exact reciprocals: ceil(2^32 / 191) for 24-bit dividends, ceil(2^20 / 25) for 15-bit
   localparam logic [24:0] POS_RECIP = 25'd22486740;
   localparam logic [15:0] KP_RECIP  = 16'd41944;

   typedef enum logic [1:0] {
      OP_CONTROL    = 2'd0,
      OP_MOTOR_MODE = 2'd1,
      OP_RESET_MODE = 2'd2,
      OP_ZERO_POS   = 2'd3
   } op_type;

   localparam logic [7:0] CMD_ENTER_MOTOR = 8'hFC;
   localparam logic [7:0] CMD_EXIT_MOTOR  = 8'hFD;
   localparam logic [7:0] CMD_ZERO_POS    = 8'hFE;
   localparam logic [55:0] FILL_BYTES     = {7{8'hFF}};

   typedef struct packed {
      op_type             op;
      logic [7:0]         motor_id;
      logic signed [15:0] position;
      logic signed [15:0] velocity;
      logic [15:0]        stiffness_gain;
      logic [15:0]        damping_gain;
      logic signed [15:0] torque_ff;
   } req_type;

   typedef struct packed {
      logic [7:0]  frame_id;
      logic [63:0] frame_bytes;
   } rsp_type;

   // Between the scale stage and the divide/pack stage
   typedef struct packed {
      op_type      op;
      logic [7:0]  motor_id;
      logic [23:0] pos_n;
      logic [11:0] vel_code;
      logic [14:0] kp_n;
      logic [11:0] kd_code;
      logic [11:0] trq_code;
   } mid_type;

endpackage

/* rtl/motor_can_command_packer_core.sv */
// Top level of the motor command packer: request register, scale stage and
// divide/pack stage. Uses mccp_pkg, mccp_scale, mccp_pack.
//
// Usage:
//   Request channel: drive req_word and raise start; the word is taken at any
//   rising edge with start high and busy low. busy is always low, so a new
//   word may be issued every cycle.
//   Result channel: rsp_word holds frame_id and the eight frame bytes for
//   exactly one cycle, marked by rsp_strobe. Results come out in request order,
//   one per request. Throughput is one frame per cycle; each request passes
//   the request register, the scale-multiply register and the
//   reciprocal-multiply register that feeds rsp_word.
//   A control request clamps and scales the five operands into a packed
//   16/12/12/12/12-bit frame; the three mode requests give seven 0xFF bytes
//   and a command byte.
//   The receiver has no back-pressure; it must take every strobed word.
//   Reset (synchronous, active high) drops any words in flight; no result
//   is strobed for a request still in flight at reset or presented during reset.
module motor_can_command_packer_core import mccp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   logic    req_valid_ff, req_valid_in;
   req_type req_word_ff;
   logic    mid_valid;
   mid_type mid_word;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_word_ff <= req_word;
   end

   mccp_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .in_word   (req_word_ff),
      .out_valid (mid_valid),
      .out_word  (mid_word)
   );

   mccp_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_word   (mid_word),
      .out_valid (rsp_strobe),
      .out_word  (rsp_word)
   );

endmodule

/* rtl/mccp_scale.sv */
// Scale stage: clamps the five operands, offsets them and multiplies by the
// reduced scale constants; registers the partial codes. Uses mccp_pkg.
module mccp_scale import mccp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_word,
   output logic    out_valid,
   output mid_type out_word
);

   localparam logic signed [16:0] POS_HI = 17'(POS_LIM);
   localparam logic signed [16:0] POS_LO = -POS_HI;
   localparam logic signed [16:0] VEL_HI = 17'(VEL_LIM);
   localparam logic signed [16:0] VEL_LO = -VEL_HI;
   localparam logic signed [16:0] TRQ_HI = 17'(TRQ_LIM);
   localparam logic signed [16:0] TRQ_LO = -TRQ_HI;

   logic signed [16:0] pos_x, vel_x, trq_x;
   logic signed [16:0] pos_c, vel_c, trq_c;
   logic signed [16:0] pos_d, vel_d, trq_d;
   logic [15:0]        pos_off;
   logic [13:0]        vel_off, trq_off;
   logic [15:0]        kp_c, kd_c;
   logic [31:0]        pos_prod;
   logic [23:0]        vel_prod, trq_prod;
   logic [25:0]        kp_prod;
   logic [19:0]        kd_prod;

   logic    valid_ff, valid_in;
   mid_type word_ff, word_in;

   always_comb begin
      pos_x = $signed({in_word.position[15], in_word.position});
      vel_x = $signed({in_word.velocity[15], in_word.velocity});
      trq_x = $signed({in_word.torque_ff[15], in_word.torque_ff});

      pos_c = (pos_x > POS_HI) ? POS_HI : ((pos_x < POS_LO) ? POS_LO : pos_x);
      vel_c = (vel_x > VEL_HI) ? VEL_HI : ((vel_x < VEL_LO) ? VEL_LO : vel_x);
      trq_c = (trq_x > TRQ_HI) ? TRQ_HI : ((trq_x < TRQ_LO) ? TRQ_LO : trq_x);
      kp_c  = (in_word.stiffness_gain > 16'(KP_LIM)) ? 16'(KP_LIM) : in_word.stiffness_gain;
      kd_c  = (in_word.damping_gain > 16'(KD_LIM)) ? 16'(KD_LIM) : in_word.damping_gain;

      // offsets are non-negative and at most the span, low bits carry them
      pos_d   = pos_c - POS_LO;
      vel_d   = vel_c - VEL_LO;
      trq_d   = trq_c - TRQ_LO;
      pos_off = pos_d[15:0];
      vel_off = vel_d[13:0];
      trq_off = trq_d[13:0];

      pos_prod = 32'(pos_off) * POS_MUL;
      vel_prod = 24'(vel_off) * VEL_MUL;
      kp_prod  = 26'(kp_c[14:0]) * KP_MUL;
      kd_prod  = 20'(kd_c[10:0]) * KD_MUL;
      trq_prod = 24'(trq_off) * TRQ_MUL;

      word_in.op       = in_word.op;
      word_in.motor_id = in_word.motor_id;
      word_in.pos_n    = pos_prod[31:8];
      word_in.vel_code = vel_prod[21:10];
      word_in.kp_n     = kp_prod[24:10];
      word_in.kd_code  = kd_prod[19:8];
      word_in.trq_code = trq_prod[21:10];
      valid_in         = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

/* rtl/mccp_pack.sv */
// Divide and pack stage: finishes the position and stiffness codes by
// reciprocal multiply, builds the frame and registers it. Uses mccp_pkg.
module mccp_pack import mccp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  mid_type in_word,
   output logic    out_valid,
   output rsp_type out_word
);

   logic [48:0] pos_prod;
   logic [31:0] kp_prod;
   logic [15:0] pos_code;
   logic [11:0] kp_code;

   logic    valid_ff, valid_in;
   rsp_type word_ff, word_in;

   always_comb begin
      pos_prod = 49'(in_word.pos_n) * 49'(POS_RECIP);
      kp_prod  = 32'(in_word.kp_n) * 32'(KP_RECIP);
      pos_code = pos_prod[47:32];
      kp_code  = kp_prod[31:20];

      word_in.frame_id = in_word.motor_id;
      case (in_word.op)
         OP_CONTROL: begin
            word_in.frame_bytes = {pos_code, in_word.vel_code, kp_code,
                                   in_word.kd_code, in_word.trq_code};
         end
         OP_MOTOR_MODE: begin
            word_in.frame_bytes = {FILL_BYTES, CMD_ENTER_MOTOR};
         end
         OP_RESET_MODE: begin
            word_in.frame_bytes = {FILL_BYTES, CMD_EXIT_MOTOR};
         end
         OP_ZERO_POS: begin
            word_in.frame_bytes = {FILL_BYTES, CMD_ZERO_POS};
         end
         default: begin
            word_in.frame_bytes = {FILL_BYTES, CMD_ZERO_POS};
         end
      endcase
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

/* rtl/mccp_checker.sv */
// Port-level checker for the motor command packer, bound to the top level.
// Uses mccp_pkg.
module mccp_checker import mccp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_word,
   input logic    rsp_strobe,
   input rsp_type rsp_word
);

   // every strobe must trace back to an earlier accepted request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 3))
      else $error("result word without a request");

   // every accepted request must yield a result word
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##2 rsp_strobe)
      else $error("request word lost");

   a_frame_id: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.frame_id == $past(req_word.motor_id, 3)))
      else $error("frame id mismatch");

   a_mode_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_word.op, 3) != OP_CONTROL))
         |-> (rsp_word.frame_bytes[63:8] == FILL_BYTES))
      else $error("mode frame fill bytes wrong");

endmodule

bind motor_can_command_packer_core mccp_checker u_checker (.*);
